FILE: src/chat_pkg.sv
// Package: constants, status codes and queue word type for the account table.
package chat_pkg;
  localparam int BUCKETS = 1024;
  localparam int ENTRIES = 1024;
  localparam int BW = $clog2(BUCKETS);
  localparam int EW = $clog2(ENTRIES);
  localparam int CW = 11;
  localparam int KW = 34;
  localparam int PW = 64;
  localparam int SW = 3;
  localparam int QDEPTH = 2;

  localparam logic [SW-1:0] ST_EXISTS    = 3'd0;
  localparam logic [SW-1:0] ST_CREATED   = 3'd1;
  localparam logic [SW-1:0] ST_LOGIN_OK  = 3'd2;
  localparam logic [SW-1:0] ST_WRONG_PW  = 3'd3;
  localparam logic [SW-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [SW-1:0] ST_FULL      = 3'd5;

  localparam logic FN_REGISTER = 1'b0;
  localparam logic FN_LOGIN    = 1'b1;

  typedef struct packed {
    logic          func;
    logic [KW-1:0] key;
    logic [PW-1:0] pw_lo;
    logic [PW-1:0] pw_hi;
    logic [BW-1:0] bucket;
  } req_t;
endpackage

FILE: src/chat_if.sv
// Interfaces: request and status channels.
interface chat_req_if;
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [chat_pkg::KW-1:0] user_id;
  logic [chat_pkg::PW-1:0] password_low;
  logic [chat_pkg::PW-1:0] password_high;
  modport source (output valid, func, user_id, password_low, password_high, input ready);
  modport sink (input valid, func, user_id, password_low, password_high, output ready);
endinterface

interface chat_rsp_if;
  logic                    valid;
  logic                    ready;
  logic [chat_pkg::SW-1:0] status;
  modport source (output valid, status, input ready);
  modport sink (input valid, status, output ready);
endinterface

FILE: src/chat_front.sv
// Front end: accept requests and reduce the key to a bucket by restoring subtraction.
module chat_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [chat_pkg::CW-1:0] bucket_count,
  chat_req_if.sink                in_ch,
  output logic                    q_valid,
  input  logic                    q_ready,
  output chat_pkg::req_t          q_word
);
  import chat_pkg::*;
  localparam int SH = KW - 1;
  localparam int SHW = $clog2(KW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SHW-1:0] step_r, step_nxt;
  logic [KW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] div_r, div_nxt;
  req_t          w_r, w_nxt;
  logic [CW-1:0] n;

  always_comb begin
    n = bucket_count;
    if (n == '0) n = CW'(1);
    if (32'(n) > BUCKETS) n = CW'(BUCKETS);
  end

  assign in_ch.ready = !busy_r && !done_r;
  assign q_valid = done_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    w_nxt = w_r;
    if (in_ch.valid && in_ch.ready) begin
      busy_nxt = 1'b1;
      step_nxt = SHW'(SH);
      rem_nxt = '0;
      div_nxt = n;
      w_nxt.func = in_ch.func;
      w_nxt.key = in_ch.user_id;
      w_nxt.pw_lo = in_ch.password_low;
      w_nxt.pw_hi = in_ch.password_high;
      w_nxt.bucket = '0;
    end else if (busy_r) begin
      if ({rem_r, w_r.key[step_r]} >= {{(KW + 1 - CW) {1'b0}}, div_r})
        rem_nxt = KW'({rem_r, w_r.key[step_r]} - {{(KW + 1 - CW) {1'b0}}, div_r});
      else
        rem_nxt = KW'({rem_r, w_r.key[step_r]});
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        w_nxt.bucket = BW'(rem_nxt);
      end else begin
        step_nxt = step_r - SHW'(1);
      end
    end else if (done_r && q_ready) begin
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    w_r <= w_nxt;
  end
  assign q_word = w_r;
endmodule

FILE: src/chat_queue.sv
// Queue: short FIFO of classified request words between front and back.
module chat_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  chat_pkg::req_t wr_word,
  output logic           rd_valid,
  input  logic           rd_ready,
  output chat_pkg::req_t rd_word
);
  import chat_pkg::*;
  localparam int AW = $clog2(QDEPTH);

  req_t          mem_r [QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign wr_ready = cnt_r != (AW + 1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_word = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= wp_r + AW'(1);
      if (rd_valid && rd_ready) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW + 1)'(wr_valid && wr_ready) - (AW + 1)'(rd_valid && rd_ready);
    end
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_word;
  end
endmodule

FILE: src/chat_back.sv
// Back end: head table, entry pool, chain walk and status register.
module chat_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  chat_pkg::req_t q_word,
  chat_rsp_if.source     out_ch
);
  import chat_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HEAD  = 3'd2;
  localparam logic [2:0] S_ENT   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [BW:0]   head_mem [BUCKETS];
  logic [KW-1:0] key_mem [ENTRIES];
  logic [PW-1:0] slo_mem [ENTRIES];
  logic [PW-1:0] shi_mem [ENTRIES];
  logic [EW:0]   link_mem [ENTRIES];

  logic [2:0]    st_r, st_nxt;
  logic [BW:0]   clr_r, clr_nxt;
  logic [EW:0]   used_r, used_nxt;
  req_t          w_r, w_nxt;
  logic [EW:0]   cur_r, cur_nxt;
  logic [EW:0]   head_r, head_nxt;
  logic [SW-1:0] stat_r, stat_nxt;
  logic [BW:0]   hd_q;
  logic [KW-1:0] k_q;
  logic [PW-1:0] lo_q, hi_q;
  logic [EW:0]   ln_q;
  logic          hwe, ewe;
  logic [BW-1:0] hwa;
  logic [BW:0]   hwd;

  assign q_ready = st_r == S_IDLE;
  assign out_ch.valid = st_r == S_OUT;
  assign out_ch.status = stat_r;

  always_comb begin
    st_nxt = st_r;
    clr_nxt = clr_r;
    used_nxt = used_r;
    w_nxt = w_r;
    cur_nxt = cur_r;
    head_nxt = head_r;
    stat_nxt = stat_r;
    hwe = 1'b0;
    ewe = 1'b0;
    hwa = w_r.bucket;
    hwd = {1'b1, BW'(used_r)};
    unique case (st_r)
      S_CLEAR: begin
        hwe = 1'b1;
        hwa = clr_r[BW-1:0];
        hwd = '0;
        clr_nxt = clr_r + (BW + 1)'(1);
        if (clr_r == (BW + 1)'(BUCKETS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          w_nxt = q_word;
          st_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        head_nxt = {hd_q[BW], EW'(hd_q[BW-1:0])};
        cur_nxt = head_nxt;
        st_nxt = S_ENT;
      end
      S_ENT: begin
        if (cur_r[EW]) begin
          st_nxt = S_CMP;
        end else begin
          st_nxt = S_OUT;
          if (w_r.func == FN_LOGIN) stat_nxt = ST_NOT_FOUND;
          else if (32'(used_r) >= ENTRIES) stat_nxt = ST_FULL;
          else begin
            stat_nxt = ST_CREATED;
            hwe = 1'b1;
            ewe = 1'b1;
            used_nxt = used_r + (EW + 1)'(1);
          end
        end
      end
      S_CMP: begin
        if (k_q == w_r.key) begin
          st_nxt = S_OUT;
          if (w_r.func == FN_REGISTER) stat_nxt = ST_EXISTS;
          else if (lo_q == w_r.pw_lo && hi_q == w_r.pw_hi) stat_nxt = ST_LOGIN_OK;
          else stat_nxt = ST_WRONG_PW;
        end else begin
          cur_nxt = ln_q;
          st_nxt = S_ENT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hwe) head_mem[hwa] <= hwd;
    hd_q <= head_mem[w_nxt.bucket];
    if (ewe) begin
      key_mem[EW'(used_r)] <= w_r.key;
      slo_mem[EW'(used_r)] <= w_r.pw_lo;
      shi_mem[EW'(used_r)] <= w_r.pw_hi;
      link_mem[EW'(used_r)] <= head_r;
    end
    k_q <= key_mem[cur_nxt[EW-1:0]];
    lo_q <= slo_mem[cur_nxt[EW-1:0]];
    hi_q <= shi_mem[cur_nxt[EW-1:0]];
    ln_q <= link_mem[cur_nxt[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      used_r <= '0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      used_r <= used_nxt;
    end
    w_r <= w_nxt;
    cur_r <= cur_nxt;
    head_r <= head_nxt;
    stat_r <= stat_nxt;
  end
endmodule

FILE: src/chained_hash_account_table.sv
// Top level: chained hash account table.
// channel | dir | words
// in_     | in  | func, user_id, password_low, password_high
// out_    | out | status
// cfg_    | in  | bucket_count, 11 bits
// Front: forms the bucket remainder one key bit per cycle, and takes no new word until the last one enters the queue.
// Back: reads the bucket head, compares the key of each chain entry visited in turn, then presents the status.
// After reset the back clears 1024 bucket heads, one per cycle, before taking words.
// A two-word queue lets the front reduce the next key while the back walks a chain.
module chained_hash_account_table (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [chat_pkg::CW-1:0] cfg_wdata,
  chat_req_if.sink                in_ch,
  chat_rsp_if.source              out_ch
);
  import chat_pkg::*;

  logic [CW-1:0] bc_r;
  logic          fq_valid, fq_ready, bq_valid, bq_ready;
  req_t          fq_word, bq_word;

  always_ff @(posedge clk) begin
    if (!rst_n) bc_r <= CW'(BUCKETS);
    else if (cfg_we) bc_r <= cfg_wdata;
  end

  chat_front u_front (.clk, .rst_n, .bucket_count(bc_r), .in_ch,
    .q_valid(fq_valid), .q_ready(fq_ready), .q_word(fq_word));
  chat_queue u_queue (.clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_word(fq_word), .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_word(bq_word));
  chat_back u_back (.clk, .rst_n, .q_valid(bq_valid), .q_ready(bq_ready),
    .q_word(bq_word), .out_ch);
endmodule

FILE: src/chat_checker.sv
// Checker: port-level properties of the account table, bound to the top level.
module chat_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [chat_pkg::SW-1:0] out_status
);
  import chat_pkg::*;
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_FULL) else $error("status code out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)) else $error("stalled word dropped");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind chained_hash_account_table chat_checker u_chk (.clk, .rst_n,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_ch.status));
